// ===== rtl/core/heatmap_color_mapper_assert.svh =====
// assertion macros for the heat colour mapper checker
`ifndef HEATMAP_COLOR_MAPPER_ASSERT_SVH
`define HEATMAP_COLOR_MAPPER_ASSERT_SVH

// checked only outside reset
`define HCM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("heatmap colour mapper assertion failed");

// checked at every edge, reset included
`define HCM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("heatmap colour mapper assertion failed");

`endif

// ===== rtl/core/hcm_pkg.sv =====
package hcm_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LUT_BITS   = 10;
    localparam int Q_BITS     = FRAC_BITS + 2;
    localparam int CHAN_BITS  = FRAC_BITS + 1;
    localparam int IDX_BITS   = LUT_BITS + 1;
    localparam int LUT_SIZE   = (1 << LUT_BITS) + 1;
    localparam int DIV_STEPS  = Q_BITS;
    localparam int COLOR_BITS = 8;

    localparam int Q30            = 30;
    localparam logic [63:0] SRGB_LIN_DIV  = 64'd329460;
    localparam logic [63:0] SRGB_GAM_DIV  = 64'd269025;
    localparam logic [63:0] SRGB_GAM_OFS  = 64'd14025;
    localparam logic [63:0] SRGB_LIN_LAST = 64'd10;

    typedef enum logic [1:0] {
        SEG_BLUE_CYAN,
        SEG_CYAN_GREEN,
        SEG_GREEN_YELLOW,
        SEG_YELLOW_RED
    } seg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] rem;
        logic [COUNT_BITS-1:0] den;
        logic [Q_BITS-1:0]     quo;
        logic                  red;
        logic                  blue;
    } div_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] r;
        logic [IDX_BITS-1:0] g;
        logic [IDX_BITS-1:0] b;
    } idx_t;

    typedef logic [COLOR_BITS-1:0] lut_t [LUT_SIZE];

    function automatic logic [63:0] pow5_q30(input logic [63:0] r);
        logic [63:0] p;
        begin
            p = r;
            for (int k = 0; k < 4; k++) begin
                p = (p * r) >> Q30;
            end
            return p;
        end
    endfunction

    // linear value at which the encoded code reaches y, q0.30
    function automatic logic [63:0] srgb_threshold(input logic [63:0] y);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        logic [63:0] c;
        begin
            r = 64'd0;
            if (y <= SRGB_LIN_LAST) begin
                return ((y * 64'd100) << Q30) / SRGB_LIN_DIV;
            end
            u  = ((y * 64'd1000 + SRGB_GAM_OFS) << Q30) / SRGB_GAM_DIV;
            u2 = (u * u) >> Q30;
            for (int b = Q30; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (pow5_q30(c) <= u2) begin
                    r = c;
                end
            end
            return (u2 * r) >> Q30;
        end
    endfunction

    function automatic logic [COLOR_BITS-1:0] lut_entry(input int idx);
        logic [63:0] x;
        logic [63:0] y;
        begin
            x = 64'(idx) << (Q30 - LUT_BITS);
            y = 64'd0;
            for (int bit_pos = COLOR_BITS - 1; bit_pos >= 0; bit_pos--) begin
                if (srgb_threshold(y | (64'd1 << bit_pos)) <= x) begin
                    y = y | (64'd1 << bit_pos);
                end
            end
            return y[COLOR_BITS-1:0];
        end
    endfunction

    function automatic lut_t build_lut();
        lut_t t;
        begin
            for (int i = 0; i < LUT_SIZE; i++) begin
                t[i] = lut_entry(i);
            end
            return t;
        end
    endfunction

    function automatic logic [IDX_BITS-1:0] chan_index(input logic [CHAN_BITS-1:0] v);
        begin
            if (FRAC_BITS >= LUT_BITS) begin
                return IDX_BITS'(v >> (FRAC_BITS - LUT_BITS));
            end else begin
                return IDX_BITS'(v) << (LUT_BITS - FRAC_BITS);
            end
        end
    endfunction

endpackage

// ===== rtl/core/hcm_div_cell.sv =====
module hcm_div_cell
    import hcm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic                  valid_reg;
    div_t                  data_reg;
    div_t                  data_next;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  take;

    // shifted remainder keeps its top bit, so the compare is one bit wider
    assign trial = {in_data.rem, 1'b0};
    assign diff  = trial - {1'b0, in_data.den};
    assign take  = trial >= {1'b0, in_data.den};

    always_comb begin
        data_next     = in_data;
        data_next.rem = take ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        data_next.quo = {in_data.quo[Q_BITS-2:0], take};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/hcm_encode.sv =====
module hcm_encode
    import hcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  div_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_BITS-1:0] out_red,
    output logic [COLOR_BITS-1:0] out_green,
    output logic [COLOR_BITS-1:0] out_blue
);

    localparam logic [CHAN_BITS-1:0] CHAN_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CHAN_BITS-1:0] CHAN_ZERO = '0;
    localparam lut_t SRGB_LUT = build_lut();

    logic                  idx_valid_reg;
    idx_t                  idx_reg;
    idx_t                  idx_next;
    logic                  idx_ready;
    logic                  col_valid_reg;
    logic [COLOR_BITS-1:0] red_reg;
    logic [COLOR_BITS-1:0] green_reg;
    logic [COLOR_BITS-1:0] blue_reg;
    logic [CHAN_BITS-1:0]  lin_r;
    logic [CHAN_BITS-1:0]  lin_g;
    logic [CHAN_BITS-1:0]  lin_b;
    logic [CHAN_BITS-1:0]  frac;
    seg_t                  seg;

    assign frac = {1'b0, in_data.quo[FRAC_BITS-1:0]};
    assign seg  = seg_t'(in_data.quo[Q_BITS-1:FRAC_BITS]);

    always_comb begin
        lin_r = CHAN_ZERO;
        lin_g = CHAN_ZERO;
        lin_b = CHAN_ZERO;
        if (in_data.red) begin
            lin_r = CHAN_ONE;
        end else if (in_data.blue) begin
            lin_b = CHAN_ONE;
        end else begin
            case (seg)
                SEG_BLUE_CYAN: begin
                    lin_g = frac;
                    lin_b = CHAN_ONE;
                end
                SEG_CYAN_GREEN: begin
                    lin_g = CHAN_ONE;
                    lin_b = CHAN_ONE - frac;
                end
                SEG_GREEN_YELLOW: begin
                    lin_r = frac;
                    lin_g = CHAN_ONE;
                end
                default: begin
                    lin_r = CHAN_ONE;
                    lin_g = CHAN_ONE - frac;
                end
            endcase
        end
        idx_next.r = chan_index(lin_r);
        idx_next.g = chan_index(lin_g);
        idx_next.b = chan_index(lin_b);
    end

    assign in_ready  = !idx_valid_reg || idx_ready;
    assign idx_ready = !col_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_valid_reg <= 1'b0;
            col_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                idx_valid_reg <= in_valid;
            end
            if (idx_ready) begin
                col_valid_reg <= idx_valid_reg;
            end
        end
    end

    // table indices and srgb table read, both registered
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            idx_reg <= idx_next;
        end
        if (idx_ready && idx_valid_reg) begin
            red_reg   <= SRGB_LUT[idx_reg.r];
            green_reg <= SRGB_LUT[idx_reg.g];
            blue_reg  <= SRGB_LUT[idx_reg.b];
        end
    end

    assign out_valid = col_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

// ===== rtl/core/heatmap_color_mapper.sv =====
// Heat colour mapper: one count in, one sRGB colour out on the blue-cyan-green-yellow-red
// scale, with count / scale_max clamped to 0..1. A new count is taken every clock cycle while
// the output is not stalled. Each transaction passes the input register, which loads on the
// accepting edge, then an 18-cell restoring divider chain (one quotient bit per cell) and two
// stages for segment mapping and the sRGB table read. Every stage has its own valid bit, so a
// stall on the output only holds the stages behind it that are full. scale_max resets to 1
// and should only be written while no transaction is in flight.
module heatmap_color_mapper
    import hcm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COLOR_BITS-1:0] m_red,
    output logic [COLOR_BITS-1:0] m_green,
    output logic [COLOR_BITS-1:0] m_blue
);

    logic [COUNT_BITS-1:0] scale_max_reg;
    logic                  in_valid_reg;
    div_t                  in_data_reg;
    div_t                  in_data_next;
    logic                  cell_valid [DIV_STEPS+1];
    logic                  cell_ready [DIV_STEPS+1];
    div_t                  cell_data  [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_max_reg <= COUNT_BITS'(1);
        end else if (cfg_wr_en) begin
            scale_max_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_data_next.rem  = s_count;
        in_data_next.den  = scale_max_reg;
        in_data_next.quo  = '0;
        in_data_next.red  = (scale_max_reg == '0) ? (s_count != '0)
                                                  : (s_count >= scale_max_reg);
        in_data_next.blue = (s_count == '0);
    end

    assign s_ready = !in_valid_reg || cell_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= in_data_next;
        end
    end

    assign cell_valid[0] = in_valid_reg;
    assign cell_data[0]  = in_data_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        hcm_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    hcm_encode u_encode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cell_valid[DIV_STEPS]),
        .in_ready  (cell_ready[DIV_STEPS]),
        .in_data   (cell_data[DIV_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_red),
        .out_green (m_green),
        .out_blue  (m_blue)
    );

endmodule

// ===== rtl/core/hcm_checker.sv =====
`include "heatmap_color_mapper_assert.svh"

module hcm_checker
    import hcm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COLOR_BITS-1:0] m_red,
    input logic [COLOR_BITS-1:0] m_green,
    input logic [COLOR_BITS-1:0] m_blue
);

    localparam logic [COLOR_BITS-1:0] FULL = '1;

    logic [3*COLOR_BITS-1:0] m_colour;

    assign m_colour = {m_red, m_green, m_blue};

    `HCM_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid)
    `HCM_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_colour))
    // full red only at the top end of the scale, where blue is off
    `HCM_ASSERT(a_red_no_blue, m_valid && m_red == FULL |-> m_blue == '0)
    // full blue only in the lower half, where red is off
    `HCM_ASSERT(a_blue_no_red, m_valid && m_blue == FULL |-> m_red == '0)

endmodule

bind heatmap_color_mapper hcm_checker u_hcm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_red   (m_red),
    .m_green (m_green),
    .m_blue  (m_blue)
);
